FILE: rtl/core/pwr_pkg.sv
// Shared types, constants and exp tables of the particle weight resampler.
package pwr_pkg;

  // Fixed field widths
  localparam int COUNT_W = 7;
  localparam int CFG_W   = 64;
  localparam int ACT_W   = 3;
  localparam int SLOT_W  = 6;
  localparam int LW_W    = 24;
  localparam int WT_W    = 16;
  localparam int FRAC_W  = 16;
  localparam int EXP_W   = 17;
  localparam int PROD_W  = 2 * EXP_W;
  localparam int SLOT_NUM = 64;

  // Exp argument at which the result is zero (13.0 in Q16.8)
  localparam int EXP_ZERO_X = 13 * 256;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_INIT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD = 3'd1;
  localparam logic [ACT_W-1:0] ACT_NORM = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DRAW = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ = 3'd4;
  localparam logic [ACT_W-1:0] ACT_BEST = 3'd5;

  // Configuration register indexes
  localparam logic CFG_PARTICLE_COUNT = 1'b0;
  localparam logic CFG_START_POSE     = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_INIT_DIV, S_INIT_WAIT, S_INIT_WR, S_LOAD, S_FAIL,
    S_MAX_RD, S_MAX_USE, S_SUM_RD, S_SUM_M1, S_SUM_M2, S_SUM_ACC, S_SUM_CHK,
    S_DIV_RD, S_DIV_M1, S_DIV_M2, S_DIV_START, S_DIV_WAIT, S_DIV_WR,
    S_DRAW_RD, S_DRAW_USE, S_BEST_RD, S_BEST_USE, S_FETCH, S_RES_OUT,
    S_DRAW_OUT, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_INIT_DIV, OP_INIT_WR, OP_LOAD, OP_FAIL,
    OP_WRD, OP_MAX_USE, OP_M1, OP_M2, OP_SUM_ACC, OP_SUM_CHK,
    OP_DIV_START, OP_DIV_WR, OP_SRD, OP_DRAW_USE, OP_BEST_USE,
    OP_FETCH, OP_RES_OUT, OP_DRAW_OUT
  } dp_op_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             last;
    logic             init_last;
    logic             hit;
    logic             count_zero;
    logic             sum_zero;
    logic             div_done;
  } dp_status_t;

  // exp(-n) in Q1.16
  function automatic logic [EXP_W-1:0] exp_int_f(input logic [3:0] n);
    logic [EXP_W-1:0] v;
    case (n)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd24110;
      4'd2:  v = 17'd8869;
      4'd3:  v = 17'd3263;
      4'd4:  v = 17'd1200;
      4'd5:  v = 17'd442;
      4'd6:  v = 17'd162;
      4'd7:  v = 17'd60;
      4'd8:  v = 17'd22;
      4'd9:  v = 17'd8;
      4'd10: v = 17'd3;
      4'd11: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-h/16) in Q1.16
  function automatic logic [EXP_W-1:0] exp_hi_f(input logic [3:0] h);
    logic [EXP_W-1:0] v;
    case (h)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd61565;
      4'd2:  v = 17'd57835;
      4'd3:  v = 17'd54331;
      4'd4:  v = 17'd51039;
      4'd5:  v = 17'd47947;
      4'd6:  v = 17'd45042;
      4'd7:  v = 17'd42313;
      4'd8:  v = 17'd39750;
      4'd9:  v = 17'd37341;
      4'd10: v = 17'd35079;
      4'd11: v = 17'd32954;
      4'd12: v = 17'd30957;
      4'd13: v = 17'd29081;
      4'd14: v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

  // exp(-l/256) in Q1.16
  function automatic logic [EXP_W-1:0] exp_lo_f(input logic [3:0] l);
    logic [EXP_W-1:0] v;
    case (l)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd65280;
      4'd2:  v = 17'd65026;
      4'd3:  v = 17'd64772;
      4'd4:  v = 17'd64520;
      4'd5:  v = 17'd64268;
      4'd6:  v = 17'd64018;
      4'd7:  v = 17'd63768;
      4'd8:  v = 17'd63520;
      4'd9:  v = 17'd63272;
      4'd10: v = 17'd63025;
      4'd11: v = 17'd62780;
      4'd12: v = 17'd62535;
      4'd13: v = 17'd62291;
      4'd14: v = 17'd62048;
      default: v = 17'd61806;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/pwr_if.sv
// Input and result channel interfaces of the particle weight resampler.
interface pwr_in_if import pwr_pkg::*; #(parameter int POSE_BITS = 64);
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [SLOT_W-1:0]       slot_index;
  logic [POSE_BITS-1:0]    pose_in;
  logic signed [LW_W-1:0]  log_weight_in;
  logic [FRAC_W-1:0]       random_fraction;

  modport source (output valid, action, slot_index, pose_in, log_weight_in,
                  random_fraction, input ready);
  modport sink (input valid, action, slot_index, pose_in, log_weight_in,
                random_fraction, output ready);
endinterface

interface pwr_out_if import pwr_pkg::*; #(parameter int POSE_BITS = 64);
  logic                 valid;
  logic                 ready;
  logic [SLOT_W-1:0]    chosen_index;
  logic [POSE_BITS-1:0] pose_out;
  logic [WT_W-1:0]      weight_out;
  logic                 status;

  modport source (output valid, chosen_index, pose_out, weight_out, status,
                  input ready);
  modport sink (input valid, chosen_index, pose_out, weight_out, status,
                output ready);
endinterface

FILE: rtl/core/particle_weight_resampler_top.sv
// Top level of the particle weight resampler: controller, datapath, ports.
//
//   Channel   Dir   Handshake              Payload
//   item      in    item.valid/ready       action slot_index pose_in log_weight_in
//                                          random_fraction
//   result    out   result.valid/ready     chosen_index pose_out weight_out status
//   cfg       in    cfg_wr_en              cfg_index cfg_data (no wait, no read-back)
//
// One item at a time; the result waits in its register until taken, then the
// next item is accepted. Init runs the divider once, then fills every slot;
// normalize scans for the max, then the sum, then divides each particle by the
// sum in the D = log2(MAX)+34 step bit-serial divider; draw stops at a hit or the last slot.
// rst is synchronous; no clearing pass is run after reset. A stalled result
// holds the block in its final state.
module particle_weight_resampler_top import pwr_pkg::*; #(
  parameter int MAX_PARTICLES = 64,
  parameter int POSE_BITS     = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  pwr_in_if.sink           item,
  pwr_out_if.source        result
);

  dp_op_t     op;
  dp_status_t status;

  pwr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .op           (op)
  );

  pwr_datapath #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .POSE_BITS     (POSE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_action (item.action),
    .item_slot   (item.slot_index),
    .item_pose   (item.pose_in),
    .item_lw     (item.log_weight_in),
    .item_frac   (item.random_fraction),
    .op          (op),
    .status      (status),
    .res_chosen  (result.chosen_index),
    .res_pose    (result.pose_out),
    .res_wt      (result.weight_out),
    .res_status  (result.status)
  );

endmodule

FILE: rtl/core/pwr_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to Q0.16.
module pwr_div import pwr_pkg::*; #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 23
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [WT_W-1:0]  quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] num_sh;
  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // Trial subtraction of one step
  assign trial = {rem, num_sh[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift in one dividend bit, retire one quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      den_q  <= den;
      num_sh <= num;
      q      <= '0;
    end else if (busy) begin
      rem    <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      q      <= {q[NUM_W-2:0], ge};
    end
  end

  // Saturate to the weight range
  assign quot = (|q[NUM_W-1:WT_W]) ? {WT_W{1'b1}} : q[WT_W-1:0];

endmodule

FILE: rtl/core/pwr_datapath.sv
// Datapath: particle banks, exp pipeline, max/sum/draw/best scans and divider.
module pwr_datapath import pwr_pkg::*; #(
  parameter int MAX_PARTICLES = 64,
  parameter int POSE_BITS     = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic [ACT_W-1:0]       item_action,
  input  logic [SLOT_W-1:0]      item_slot,
  input  logic [POSE_BITS-1:0]   item_pose,
  input  logic [LW_W-1:0]        item_lw,
  input  logic [FRAC_W-1:0]      item_frac,
  input  dp_op_t                 op,
  output dp_status_t             status,
  output logic [SLOT_W-1:0]      res_chosen,
  output logic [POSE_BITS-1:0]   res_pose,
  output logic [WT_W-1:0]        res_wt,
  output logic                   res_status
);

  localparam int IDX_W = $clog2(MAX_PARTICLES);
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int SUM_W = EXP_W + IDX_W;
  localparam int NUM_W = SUM_W + EXP_W;
  localparam int X_W   = LW_W + 1;

  // Configuration registers
  logic [COUNT_W-1:0]   particle_count;
  logic [POSE_BITS-1:0] start_pose;

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= COUNT_W'(64);
      start_pose     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PARTICLE_COUNT: particle_count <= cfg_data[COUNT_W-1:0];
        CFG_START_POSE:     start_pose     <= cfg_data[POSE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective particle count
  logic [CMP_W-1:0] cnt_ext;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] nn;
  logic [IDX_W-1:0] last_idx;
  logic             count_zero;

  always_comb begin
    cnt_ext = CMP_W'(particle_count);
    if (cnt_ext > CMP_W'(MAX_PARTICLES)) n_eff = CNT_W'(MAX_PARTICLES);
    else n_eff = CNT_W'(cnt_ext);
    count_zero = (particle_count == '0);
    nn         = count_zero ? CNT_W'(1) : n_eff;
    last_idx   = IDX_W'(nn - CNT_W'(1));
  end

  // Slot wrap table
  logic [IDX_W-1:0] slot_lut [SLOT_NUM];
  for (genvar k = 0; k < SLOT_NUM; k++) begin : g_slot_lut
    assign slot_lut[k] = IDX_W'(k % MAX_PARTICLES);
  end

  // Captured item and scan registers
  logic [ACT_W-1:0]       act;
  logic [IDX_W-1:0]       slot;
  logic [POSE_BITS-1:0]   pose_q;
  logic [LW_W-1:0]        lw_q;
  logic [FRAC_W-1:0]      frac_q;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       pick;
  logic signed [LW_W-1:0] mx;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       cum;
  logic [WT_W-1:0]        bestw;
  logic [PROD_W-1:0]      p1;
  logic [PROD_W-1:0]      p2;
  logic [3:0]             lsel;
  logic                   xzero;

  // Particle banks and their read registers
  logic [POSE_BITS-1:0] wk_pose_mem [MAX_PARTICLES];
  logic [LW_W-1:0]      wk_lw_mem   [MAX_PARTICLES];
  logic [POSE_BITS-1:0] st_pose_mem [MAX_PARTICLES];
  logic [WT_W-1:0]      st_wt_mem   [MAX_PARTICLES];
  logic [POSE_BITS-1:0] wk_pose_rd;
  logic [LW_W-1:0]      wk_lw_rd;
  logic [POSE_BITS-1:0] st_pose_rd;
  logic [WT_W-1:0]      st_wt_rd;

  // Divider hookup
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [SUM_W-1:0] div_den;
  logic             div_done;
  logic [WT_W-1:0]  div_q;

  // Combinational datapath signals
  logic                   wk_we;
  logic [POSE_BITS-1:0]   wk_wpose;
  logic [LW_W-1:0]        wk_wlw;
  logic                   st_we;
  logic [POSE_BITS-1:0]   st_wpose;
  logic                   st_re;
  logic [IDX_W-1:0]       st_raddr;
  logic signed [LW_W-1:0] lw_v;
  logic signed [X_W-1:0]  x_s;
  logic                   x_big;
  logic [PROD_W-1:0]      p1_next;
  logic [PROD_W-1:0]      t_full;
  logic [PROD_W-1:0]      p2_next;
  logic [PROD_W-1:0]      e_full;
  logic [EXP_W-1:0]       e_val;
  logic [SUM_W-1:0]       cum_next;
  logic                   hit;
  logic                   last;
  logic                   init_last;
  logic [IDX_W-1:0]       idx_adv;

  always_comb begin
    // Memory port selection
    wk_we    = (op == OP_LOAD) || (op == OP_DRAW_OUT);
    wk_wpose = (op == OP_LOAD) ? pose_q : st_pose_rd;
    wk_wlw   = (op == OP_LOAD) ? lw_q : LW_W'(st_wt_rd);
    st_we    = (op == OP_INIT_WR) || (op == OP_DIV_WR);
    st_wpose = (op == OP_INIT_WR) ? start_pose : wk_pose_rd;
    st_re    = (op == OP_SRD) || (op == OP_FETCH);
    st_raddr = (op == OP_FETCH) ? pick : idx;

    // Exp argument and split into integer, high and low nibbles
    lw_v    = signed'(wk_lw_rd);
    x_s     = X_W'(mx) - X_W'(lw_v);
    x_big   = x_s >= X_W'(EXP_ZERO_X);
    p1_next = exp_int_f(x_s[11:8]) * exp_hi_f(x_s[7:4]);
    t_full  = p1 + PROD_W'(32768);
    p2_next = t_full[32:16] * exp_lo_f(lsel);
    e_full  = p2 + PROD_W'(32768);
    e_val   = xzero ? '0 : e_full[32:16];

    // Divider operands
    div_start = (op == OP_INIT_DIV) || (op == OP_DIV_START);
    if (op == OP_INIT_DIV) begin
      div_num = NUM_W'(65536) + NUM_W'(nn >> 1);
      div_den = SUM_W'(nn);
    end else begin
      div_num = NUM_W'({e_val, 16'b0}) + NUM_W'(sum >> 1);
      div_den = sum;
    end

    // Scan status
    cum_next  = cum + SUM_W'(st_wt_rd);
    hit       = cum_next >= SUM_W'(frac_q);
    last      = (idx == last_idx);
    init_last = (idx == IDX_W'(MAX_PARTICLES - 1));
    idx_adv   = last ? '0 : idx + 1'b1;
  end

  pwr_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // Working bank
  always_ff @(posedge clk) begin
    if (wk_we) begin
      wk_pose_mem[slot] <= wk_wpose;
      wk_lw_mem[slot]   <= wk_wlw;
    end
    if (op == OP_WRD) begin
      wk_pose_rd <= wk_pose_mem[idx];
      wk_lw_rd   <= wk_lw_mem[idx];
    end
  end

  // Settled bank
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_pose_mem[idx] <= st_wpose;
      st_wt_mem[idx]   <= div_q;
    end
    if (st_re) begin
      st_pose_rd <= st_pose_mem[st_raddr];
      st_wt_rd   <= st_wt_mem[st_raddr];
    end
  end

  // Per-operation register updates
  always_ff @(posedge clk) begin
    case (op)
      OP_CAPTURE: begin
        act        <= item_action;
        slot       <= slot_lut[item_slot];
        pick       <= slot_lut[item_slot];
        pose_q     <= item_pose;
        lw_q       <= item_lw;
        frac_q     <= item_frac;
        idx        <= '0;
        cum        <= '0;
        sum        <= '0;
        res_chosen <= '0;
        res_pose   <= '0;
        res_wt     <= '0;
        res_status <= 1'b0;
      end
      OP_INIT_WR: idx <= init_last ? '0 : idx + 1'b1;
      OP_FAIL:    res_status <= 1'b1;
      OP_MAX_USE: begin
        if ((idx == '0) || (lw_v > mx)) mx <= lw_v;
        idx <= idx_adv;
      end
      OP_M1: begin
        p1    <= p1_next;
        lsel  <= x_s[3:0];
        xzero <= x_big;
      end
      OP_M2:      p2 <= p2_next;
      OP_SUM_ACC: begin
        sum <= sum + SUM_W'(e_val);
        idx <= idx_adv;
      end
      OP_SUM_CHK: res_status <= (sum == '0);
      OP_DIV_WR:  idx <= idx_adv;
      OP_DRAW_USE: begin
        cum  <= cum_next;
        pick <= idx;
        idx  <= idx_adv;
      end
      OP_BEST_USE: begin
        if ((idx == '0) || (st_wt_rd > bestw)) begin
          bestw <= st_wt_rd;
          pick  <= idx;
        end
        idx <= idx_adv;
      end
      OP_RES_OUT, OP_DRAW_OUT: begin
        res_chosen <= SLOT_W'(pick);
        res_pose   <= st_pose_rd;
        res_wt     <= st_wt_rd;
      end
      default: ;
    endcase
  end

  // Status toward the controller
  always_comb begin
    status.act        = act;
    status.last       = last;
    status.init_last  = init_last;
    status.hit        = hit;
    status.count_zero = count_zero;
    status.sum_zero   = (sum == '0);
    status.div_done   = div_done;
  end

endmodule

FILE: rtl/core/pwr_ctrl.sv
// Controller: sequences each action over the datapath and runs the handshakes.
module pwr_ctrl import pwr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  output logic       result_valid,
  input  logic       result_ready,
  input  dp_status_t status,
  output dp_op_t     op
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (item_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        case (status.act)
          ACT_INIT: state_next = S_INIT_DIV;
          ACT_LOAD: state_next = S_LOAD;
          ACT_NORM: state_next = status.count_zero ? S_FAIL : S_MAX_RD;
          ACT_DRAW: state_next = S_DRAW_RD;
          ACT_READ: state_next = S_FETCH;
          ACT_BEST: state_next = S_BEST_RD;
          default:  state_next = S_DONE;
        endcase
      end
      S_INIT_DIV:  state_next = S_INIT_WAIT;
      S_INIT_WAIT: if (status.div_done) state_next = S_INIT_WR;
      S_INIT_WR:   if (status.init_last) state_next = S_DONE;
      S_LOAD:      state_next = S_DONE;
      S_FAIL:      state_next = S_DONE;
      S_MAX_RD:    state_next = S_MAX_USE;
      S_MAX_USE:   state_next = status.last ? S_SUM_RD : S_MAX_RD;
      S_SUM_RD:    state_next = S_SUM_M1;
      S_SUM_M1:    state_next = S_SUM_M2;
      S_SUM_M2:    state_next = S_SUM_ACC;
      S_SUM_ACC:   state_next = status.last ? S_SUM_CHK : S_SUM_RD;
      S_SUM_CHK:   state_next = status.sum_zero ? S_DONE : S_DIV_RD;
      S_DIV_RD:    state_next = S_DIV_M1;
      S_DIV_M1:    state_next = S_DIV_M2;
      S_DIV_M2:    state_next = S_DIV_START;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT:  if (status.div_done) state_next = S_DIV_WR;
      S_DIV_WR:    state_next = status.last ? S_DONE : S_DIV_RD;
      S_DRAW_RD:   state_next = S_DRAW_USE;
      S_DRAW_USE:  if (status.hit || status.last) state_next = S_FETCH;
                   else state_next = S_DRAW_RD;
      S_BEST_RD:   state_next = S_BEST_USE;
      S_BEST_USE:  state_next = status.last ? S_FETCH : S_BEST_RD;
      S_FETCH:     state_next = (status.act == ACT_DRAW) ? S_DRAW_OUT : S_RES_OUT;
      S_RES_OUT:   state_next = S_DONE;
      S_DRAW_OUT:  state_next = S_DONE;
      S_DONE:      if (result_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Datapath command and handshake outputs
  always_comb begin
    item_ready   = (state == S_IDLE);
    result_valid = (state == S_DONE);
    case (state)
      S_IDLE:      op = item_valid ? OP_CAPTURE : OP_NONE;
      S_INIT_DIV:  op = OP_INIT_DIV;
      S_INIT_WR:   op = OP_INIT_WR;
      S_LOAD:      op = OP_LOAD;
      S_FAIL:      op = OP_FAIL;
      S_MAX_RD:    op = OP_WRD;
      S_MAX_USE:   op = OP_MAX_USE;
      S_SUM_RD:    op = OP_WRD;
      S_SUM_M1:    op = OP_M1;
      S_SUM_M2:    op = OP_M2;
      S_SUM_ACC:   op = OP_SUM_ACC;
      S_SUM_CHK:   op = OP_SUM_CHK;
      S_DIV_RD:    op = OP_WRD;
      S_DIV_M1:    op = OP_M1;
      S_DIV_M2:    op = OP_M2;
      S_DIV_START: op = OP_DIV_START;
      S_DIV_WR:    op = OP_DIV_WR;
      S_DRAW_RD:   op = OP_SRD;
      S_DRAW_USE:  op = OP_DRAW_USE;
      S_BEST_RD:   op = OP_SRD;
      S_BEST_USE:  op = OP_BEST_USE;
      S_FETCH:     op = OP_FETCH;
      S_RES_OUT:   op = OP_RES_OUT;
      S_DRAW_OUT:  op = OP_DRAW_OUT;
      default:     op = OP_NONE;
    endcase
  end

endmodule

FILE: rtl/core/pwr_checker.sv
// Port-level assertions of the particle weight resampler and their bind.
module pwr_checker import pwr_pkg::*; #(
  parameter int POSE_BITS = 64
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input logic [SLOT_W-1:0]    chosen_index,
  input logic [POSE_BITS-1:0] pose_out,
  input logic [WT_W-1:0]      weight_out,
  input logic                 status
);

  // One transaction in flight: never ready for input while a result is shown
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("input ready while a result is pending");

  // An accepted item never yields its result in the next cycle
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !result_valid)
    else $error("result shown right after accept");

  // After the result transaction the block takes input again
  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready) |=> item_ready)
    else $error("not ready after result taken");

  // A failed normalize carries no particle
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status) |-> (chosen_index == '0 && weight_out == '0))
    else $error("status set with particle data");

  // A stalled result holds its pose
  a_hold_pose: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(pose_out)))
    else $error("stalled result changed");

endmodule

bind particle_weight_resampler_top pwr_checker #(.POSE_BITS(POSE_BITS)) u_pwr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .chosen_index (result.chosen_index),
  .pose_out     (result.pose_out),
  .weight_out   (result.weight_out),
  .status       (result.status)
);
